>>> hw/rtl/uos_pkg.sv
// Shared types and codes for the unique option stack.
`timescale 1ns / 1ps

package uos_pkg;

	// Default number of stack entries
	localparam int DEPTH_DEFAULT = 16;

	// Command codes
	localparam logic [1:0] CMD_PUSH = 2'd0;
	localparam logic [1:0] CMD_POP  = 2'd1;
	localparam logic [1:0] CMD_PEEK = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DUP   = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// Shift control broadcast to every cell of the chain
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctl_t;

endpackage

>>> hw/rtl/uos_cmd_if.sv
// Command channel: valid/ready handshake carrying cmd and push_value.
`timescale 1ns / 1ps

interface uos_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic signed [31:0] push_value;

	modport source (output valid, output cmd, output push_value, input ready);
	modport sink (input valid, input cmd, input push_value, output ready);
endinterface

>>> hw/rtl/uos_res_if.sv
// Result channel: valid/ready handshake carrying the stack status after each item.
`timescale 1ns / 1ps

interface uos_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] top_value;
	logic [4:0]         entry_count;
	logic               is_empty;

	modport source (output valid, output status, output top_value, output entry_count,
		output is_empty, input ready);
	modport sink (input valid, input status, input top_value, input entry_count,
		input is_empty, output ready);
endinterface

>>> hw/rtl/uos_cell.sv
// One stack cell: holds an entry, shifts with its neighbors, compares against the push value.
`timescale 1ns / 1ps

module uos_cell (
	input  logic                clk,
	input  uos_pkg::cell_ctl_t  ctl,
	input  logic                occupied,
	input  logic signed [31:0]  above,
	input  logic signed [31:0]  below,
	input  logic signed [31:0]  cmp_value,
	output logic signed [31:0]  value,
	output logic                match
);

	logic signed [31:0] value_q;

	// Push moves entries away from the top, pop moves them toward it
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			value_q <= above;
		end else if (ctl.pop) begin
			value_q <= below;
		end
	end

	// Duplicate check only counts live entries
	assign match = occupied && (value_q == cmp_value);
	assign value = value_q;

endmodule

>>> hw/rtl/unique_option_stack_core.sv
// Top level of the unique option stack: cell chain, entry count and result register.
`timescale 1ns / 1ps

// Bounded LIFO stack of signed 32-bit values built as a chain of DEPTH cells, cell 0 being
// the top. A push shifts every cell one place down, a pop shifts one place up, and every
// cell compares its entry against the incoming push value in the same cycle, so one item
// is taken each clock; its result appears in the output register on the next edge. The
// rate is one item per cycle while no result is left unclaimed, set by the shift and compare in the cell chain;
// the command side only waits while a result sits unclaimed in the output register. Stack
// contents need no clearing after reset: only entries below the count are ever looked at.
module unique_option_stack_core #(
	parameter int DEPTH = uos_pkg::DEPTH_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	uos_cmd_if.sink       req,
	uos_res_if.source     rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	logic                     unique_mode_q;
	logic [CW-1:0]            count_q;
	logic                     rsp_valid_q;
	logic [1:0]               status_q;
	logic signed [31:0]       top_q;
	logic [CW-1:0]            count_out_q;

	logic                     acc;
	uos_pkg::cell_ctl_t       ctl;
	logic signed [31:0]       cell_val [DEPTH];
	logic [DEPTH-1:0]         occupied;
	logic [DEPTH-1:0]         match;
	logic signed [31:0]       second_value;
	logic                     is_push;
	logic                     is_pop;
	logic                     dup;
	logic                     full;
	logic                     empty;
	logic [1:0]               status_d;
	logic [CW-1:0]            count_d;
	logic signed [31:0]       top_d;

	// Cell chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [31:0] above_v;
		logic signed [31:0] below_v;

		if (i == 0) begin : g_head
			assign above_v = req.push_value;
		end else begin : g_mid
			assign above_v = cell_val[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign below_v = '0;
		end else begin : g_body
			assign below_v = cell_val[i+1];
		end

		assign occupied[i] = CW'(i) < count_q;

		uos_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (occupied[i]),
			.above     (above_v),
			.below     (below_v),
			.cmp_value (req.push_value),
			.value     (cell_val[i]),
			.match     (match[i])
		);
	end

	// Entry just under the top, the new top after a pop
	if (DEPTH > 1) begin : g_second
		assign second_value = cell_val[1];
	end else begin : g_no_second
		assign second_value = '0;
	end

	// Handshake: take an item whenever the output register is free or draining
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;

	// Command decode and outcome
	assign is_push = req.cmd == uos_pkg::CMD_PUSH;
	assign is_pop  = req.cmd == uos_pkg::CMD_POP;
	assign dup     = unique_mode_q && (|match);
	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;

	always_comb begin
		status_d = uos_pkg::ST_OK;
		count_d  = count_q;
		top_d    = empty ? 32'sd0 : cell_val[0];
		ctl      = '0;
		priority if (is_push) begin
			priority if (dup) begin
				status_d = uos_pkg::ST_DUP;
			end else if (full) begin
				status_d = uos_pkg::ST_FULL;
			end else begin
				ctl.push = acc;
				count_d  = count_q + CW'(1);
				top_d    = req.push_value;
			end
		end else if (is_pop) begin
			if (empty) begin
				status_d = uos_pkg::ST_EMPTY;
			end else begin
				ctl.pop = acc;
				count_d = count_q - CW'(1);
				top_d   = (count_q == CW'(1)) ? 32'sd0 : second_value;
			end
		end else begin
			// Peek, and the unused code behaves the same
			if (empty) begin
				status_d = uos_pkg::ST_EMPTY;
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unique_mode_q <= 1'b0;
			count_q       <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique_mode_q <= cfg_wdata;
			end
			if (acc) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (acc) begin
			status_q    <= status_d;
			top_q       <= top_d;
			count_out_q <= count_d;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.top_value   = top_q;
	assign rsp.entry_count = 5'(count_out_q);
	assign rsp.is_empty    = count_out_q == '0;

endmodule
